// ===== sv/nscf_pkg.sv =====
// ----------------------------------------------------------------------------
// nscf_pkg
// Types and constants shared by the start code fragmenter modules.
// ----------------------------------------------------------------------------
package nscf_pkg;

    localparam int POSITION_BITS_DEF       = 24;
    localparam int FRAGMENT_INDEX_BITS_DEF = 12;

    // fixed widths of the result fields
    localparam int OUT_POS_W   = 24;
    localparam int OUT_INDEX_W = 12;

    localparam logic [4:0] NAL_TYPE_AUD = 5'h09;
    localparam logic [4:0] NAL_TYPE_IDR = 5'h05;
    localparam logic [2:0] SKIP_COUNT   = 3'd5;

    localparam logic [2:0] CODE_NONE = 3'd0;
    localparam logic [2:0] CODE_3    = 3'd3;
    localparam logic [2:0] CODE_4    = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       clean_point_hint;
    } t_in_word;

    typedef struct packed {
        logic                   fragment_valid;
        logic [OUT_POS_W-1:0]   fragment_offset;
        logic [OUT_POS_W-1:0]   fragment_length;
        logic [OUT_INDEX_W-1:0] fragment_index;
        logic                   frame_end;
        logic                   key_frame;
        logic [OUT_INDEX_W-1:0] fragment_count;
        logic                   overflow;
    } t_out_word;

    typedef struct packed {
        logic       hit;
        logic [2:0] code_len;
        logic       idr;
    } t_hit;

endpackage

// ===== sv/nscf_detect.sv =====
// ----------------------------------------------------------------------------
// nscf_detect
// Checks a five-byte window for a 3- or 4-byte start code that is not
// followed by an access unit delimiter.
// ----------------------------------------------------------------------------
module nscf_detect (
    input  logic [39:0]       i_window,
    output nscf_pkg::t_hit    o_hit
);
    import nscf_pkg::*;

    logic [7:0] b0, b1, b2, b3, b4;
    logic       code4, code3;

    assign b0 = i_window[39:32];
    assign b1 = i_window[31:24];
    assign b2 = i_window[23:16];
    assign b3 = i_window[15:8];
    assign b4 = i_window[7:0];

    assign code4 = (b0 == 8'h00) && (b1 == 8'h00) && (b2 == 8'h00) && (b3 == 8'h01)
                   && (b4[4:0] != NAL_TYPE_AUD);
    assign code3 = (b0 == 8'h00) && (b1 == 8'h00) && (b2 == 8'h01)
                   && (b3[4:0] != NAL_TYPE_AUD);

    always_comb begin
        o_hit = '0;
        priority if (code4) begin
            o_hit.hit      = 1'b1;
            o_hit.code_len = CODE_4;
            o_hit.idr      = (b4[4:0] == NAL_TYPE_IDR);
        end else if (code3) begin
            o_hit.hit      = 1'b1;
            o_hit.code_len = CODE_3;
            o_hit.idr      = (b3[4:0] == NAL_TYPE_IDR);
        end else begin
            o_hit.hit      = 1'b0;
            o_hit.code_len = CODE_NONE;
            o_hit.idr      = 1'b0;
        end
    end

endmodule

// ===== sv/nscf_core.sv =====
// ----------------------------------------------------------------------------
// nscf_core
// Per-sample scan state and result formation, one word per step.
// ----------------------------------------------------------------------------
module nscf_core #(
    parameter int POSITION_BITS       = nscf_pkg::POSITION_BITS_DEF,
    parameter int FRAGMENT_INDEX_BITS = nscf_pkg::FRAGMENT_INDEX_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  nscf_pkg::t_in_word  i_word,
    output logic                o_emit,
    output nscf_pkg::t_out_word o_result
);
    import nscf_pkg::*;

    localparam int PW = POSITION_BITS;
    localparam int FW = FRAGMENT_INDEX_BITS;
    localparam logic [PW-1:0] PMAX = '1;
    localparam logic [FW-1:0] FMAX = '1;

    logic [39:0]   r_window, n_window;
    logic [PW-1:0] r_pos, n_pos;
    logic [2:0]    r_skip, n_skip;
    logic [PW-1:0] r_prev, n_prev;
    logic [FW-1:0] r_count, n_count;
    logic          r_key, n_key;
    logic          r_range, n_range;

    t_hit          hit;
    logic [39:0]   shift_win;
    logic          pos_sat;
    logic [PW:0]   end_pos, end_diff;
    logic [PW-1:0] end_len, start_pos, hit_len;

    assign shift_win = {r_window[31:0], i_word.data_byte};

    nscf_detect u_detect (
        .i_window (shift_win),
        .o_hit    (hit)
    );

    assign pos_sat   = (r_pos == PMAX);
    assign start_pos = r_pos - PW'(4);

    // final fragment runs through the current byte
    assign end_pos  = {1'b0, r_pos} + {{PW{1'b0}}, 1'b1};
    assign end_diff = end_pos - {1'b0, r_prev};
    always_comb begin
        if (end_pos <= {1'b0, r_prev}) begin
            end_len = '0;
        end else if (end_diff[PW]) begin
            end_len = PMAX;
        end else begin
            end_len = end_diff[PW-1:0];
        end
    end

    assign hit_len = (start_pos > r_prev) ? (start_pos - r_prev) : '0;

    always_comb begin
        n_window = shift_win;
        n_pos    = pos_sat ? r_pos : r_pos + PW'(1);
        n_range  = r_range | pos_sat;
        n_key    = r_key | i_word.clean_point_hint;
        n_skip   = r_skip;
        n_prev   = r_prev;
        n_count  = r_count;
        o_emit   = 1'b0;
        o_result = '0;

        if (i_word.last_byte) begin
            if ((end_pos > {1'b0, r_prev}) && end_diff[PW] && (r_count != '0)) begin
                n_range = 1'b1;
            end
            o_emit                  = 1'b1;
            o_result.frame_end      = 1'b1;
            o_result.key_frame      = n_key;
            o_result.fragment_count = OUT_INDEX_W'(r_count);
            o_result.overflow       = n_range;
            if (r_count != '0) begin
                o_result.fragment_valid  = 1'b1;
                o_result.fragment_offset = OUT_POS_W'(r_prev);
                o_result.fragment_length = OUT_POS_W'(end_len);
                o_result.fragment_index  = OUT_INDEX_W'(r_count - FW'(1));
            end
            // per-sample state clears after the frame end
            n_window = '0;
            n_pos    = '0;
            n_skip   = '0;
            n_prev   = '0;
            n_count  = '0;
            n_key    = 1'b0;
            n_range  = 1'b0;
        end else if (r_pos[PW-1:2] != '0) begin
            if (r_skip != 3'd0) begin
                n_skip = r_skip - 3'd1;
            end else if (hit.hit) begin
                n_key  = n_key | hit.idr;
                n_skip = SKIP_COUNT;
                if (r_count != '0) begin
                    o_emit                   = 1'b1;
                    o_result.fragment_valid  = 1'b1;
                    o_result.fragment_offset = OUT_POS_W'(r_prev);
                    o_result.fragment_length = OUT_POS_W'(hit_len);
                    o_result.fragment_index  = OUT_INDEX_W'(r_count - FW'(1));
                end
                n_prev = start_pos + PW'(hit.code_len);
                if (r_count != FMAX) begin
                    n_count = r_count + FW'(1);
                end else begin
                    n_range = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_pos    <= '0;
            r_skip   <= '0;
            r_prev   <= '0;
            r_count  <= '0;
            r_key    <= 1'b0;
            r_range  <= 1'b0;
        end else if (i_step) begin
            r_window <= n_window;
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_prev   <= n_prev;
            r_count  <= n_count;
            r_key    <= n_key;
            r_range  <= n_range;
        end
    end

endmodule

// ===== sv/nal_start_code_fragmenter.sv =====
// ----------------------------------------------------------------------------
// nal_start_code_fragmenter
// Splits one encoded sample, fed a byte at a time, into NAL fragments at
// Annex B start codes and reports a frame summary on the last byte.
//
//   channel | valid      | ready       | word
//   --------+------------+-------------+--------------------------
//   in      | i_in_valid | o_in_ready  | i_in_word  (t_in_word)
//   out     | o_out_valid| i_out_ready | o_out_word (t_out_word)
//
// One byte per cycle while no result is left waiting; each byte goes through the
// input register, then the scan step into the result register.
// Synchronous active-low reset clears the scan state and both valid flags.
// A result left waiting stalls the scan step; the input register keeps its
// word (or takes one if empty), then ready stays low until the result is taken.
// ----------------------------------------------------------------------------
module nal_start_code_fragmenter #(
    parameter int POSITION_BITS       = nscf_pkg::POSITION_BITS_DEF,
    parameter int FRAGMENT_INDEX_BITS = nscf_pkg::FRAGMENT_INDEX_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  nscf_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output nscf_pkg::t_out_word o_out_word
);
    import nscf_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      step;
    logic      emit;
    t_out_word result;

    // scan step runs when the input register holds a word and the result register is free or being emptied
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    nscf_core #(
        .POSITION_BITS       (POSITION_BITS),
        .FRAGMENT_INDEX_BITS (FRAGMENT_INDEX_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for nal_start_code_fragmenter. A short directed table is followed
// by random samples built from start codes, NAL headers and zero-heavy
// payload, mixed with short samples, noise and broken codes. Each accepted
// input word runs through a scan model in the bench; results are checked in
// order against the fragments it predicts. Both sides idle at random, and the
// receiver holds off once for a long stretch so the block fills up.
// ----------------------------------------------------------------------------
module tb_top;
    import nscf_pkg::*;

    localparam logic [23:0] POS_MAX  = 24'hFFFFFF;
    localparam logic [11:0] FRAG_MAX = 12'hFFF;
    localparam int          RANDOM_WORDS = 1150;

    typedef struct packed {
        t_in_word  word;
        logic      typed;
        t_out_word res;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    // scan model state
    logic [39:0] win       = '0;
    logic [23:0] pos       = '0;
    logic [2:0]  skip_left = '0;
    logic [23:0] frag_off  = '0;
    logic [11:0] nfrag     = '0;
    logic        key_seen  = 1'b0;
    logic        range_ovf = 1'b0;

    t_out_word   pending_frags[$];
    logic [7:0]  sample_q[$];
    int          n_bad    = 0;
    int          n_sent   = 0;
    logic        steady   = 1'b0;
    logic        rand_phase = 1'b0;
    logic        hold     = 1'b0;
    logic        rx_steady = 1'b0;
    int          rx_stall = 0;

    // directed table: typed results only for the short samples
    t_row directed_rows [24] = '{
        '{'{8'hFF, 1'b1, 1'b1}, 1'b1,
          '{1'b0, 24'd0, 24'd0, 12'd0, 1'b1, 1'b1, 12'd0, 1'b0}},
        '{'{8'h00, 1'b1, 1'b0}, 1'b1,
          '{1'b0, 24'd0, 24'd0, 12'd0, 1'b1, 1'b0, 12'd0, 1'b0}},
        // 4-byte IDR code in a 5-byte sample: never scanned
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h65, 1'b1, 1'b0}, 1'b1,
          '{1'b0, 24'd0, 24'd0, 12'd0, 1'b1, 1'b0, 12'd0, 1'b0}},
        // IDR hit, AUD codes rejected, second hit, end
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h65, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'hAA, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'hBB, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h09, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h41, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b1, 1'b0}, 1'b0, '0}
    };

    nal_start_code_fragmenter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #16000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // payload byte, heavy on zeros and ones so codes show up by chance
    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 8'h00;
        else if (r < 35)
            return 8'h01;
        else if (r < 40)
            return 8'h03;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int next_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic string fmt_word(input t_out_word w);
        return $sformatf("v%0d off %0d len %0d idx %0d end %0d key %0d cnt %0d ovf %0d",
                         w.fragment_valid, w.fragment_offset, w.fragment_length,
                         w.fragment_index, w.frame_end, w.key_frame,
                         w.fragment_count, w.overflow);
    endfunction

    // length from start to stop, zero if negative, saturating with overflow
    function automatic logic [23:0] span_len(input logic [24:0] stop,
                                             input logic [23:0] start);
        logic [24:0] d;
        if (stop <= {1'b0, start})
            return '0;
        d = stop - {1'b0, start};
        if (d > {1'b0, POS_MAX}) begin
            range_ovf = 1'b1;
            return POS_MAX;
        end
        return d[23:0];
    endfunction

    // one byte through the scan model; has_res tells whether a result is due
    task automatic scan_byte(input t_in_word w, output logic has_res,
                             output t_out_word r);
        logic [23:0] p;
        logic [23:0] cand;
        logic [2:0]  code;
        logic [7:0]  hdr;
        begin
            r       = '0;
            has_res = 1'b0;
            if (w.clean_point_hint)
                key_seen = 1'b1;
            win = {win[31:0], w.data_byte};
            p   = pos;
            if (pos != POS_MAX)
                pos = pos + 24'd1;
            else
                range_ovf = 1'b1;

            if (w.last_byte) begin
                has_res          = 1'b1;
                r.frame_end      = 1'b1;
                r.key_frame      = key_seen;
                r.fragment_count = nfrag;
                if (nfrag != '0) begin
                    r.fragment_valid  = 1'b1;
                    r.fragment_offset = frag_off;
                    r.fragment_length = span_len({1'b0, p} + 25'd1, frag_off);
                    r.fragment_index  = nfrag - 12'd1;
                end
                r.overflow = range_ovf;
                win       = '0;
                pos       = '0;
                skip_left = '0;
                frag_off  = '0;
                nfrag     = '0;
                key_seen  = 1'b0;
                range_ovf = 1'b0;
                return;
            end

            if (p < 24'd4)
                return;
            if (skip_left != '0) begin
                skip_left = skip_left - 3'd1;
                return;
            end

            code = CODE_NONE;
            hdr  = '0;
            if (win[39:8] == 32'h0000_0001 && win[4:0] != NAL_TYPE_AUD) begin
                code = CODE_4;
                hdr  = win[7:0];
            end else if (win[39:16] == 24'h00_0001 && win[12:8] != NAL_TYPE_AUD) begin
                code = CODE_3;
                hdr  = win[15:8];
            end
            if (code == CODE_NONE)
                return;

            if (hdr[4:0] == NAL_TYPE_IDR)
                key_seen = 1'b1;
            skip_left = SKIP_COUNT;
            cand      = p - 24'd4;
            if (nfrag != '0) begin
                has_res           = 1'b1;
                r.fragment_valid  = 1'b1;
                r.fragment_offset = frag_off;
                r.fragment_length = span_len({1'b0, cand}, frag_off);
                r.fragment_index  = nfrag - 12'd1;
            end
            frag_off = cand + 24'(code);
            if (nfrag != FRAG_MAX)
                nfrag = nfrag + 12'd1;
            else
                range_ovf = 1'b1;
        end
    endtask

    // offer one word, wait for it to be taken, then predict its result
    task automatic send_word(input t_in_word w, input logic typed,
                             input t_out_word typed_res);
        int        gap;
        logic      has_res;
        t_out_word r;
        begin
            gap = next_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_word  <= w;
            @(posedge i_clk);
            while (!o_in_ready)
                @(posedge i_clk);
            n_sent++;
            scan_byte(w, has_res, r);
            if (typed)
                pending_frags.push_back(typed_res);
            else if (has_res)
                pending_frags.push_back(r);
        end
    endtask

    task automatic send_sample(input int hint_at);
        t_in_word w;
        begin
            steady = ($urandom_range(0, 3) == 0);
            foreach (sample_q[k]) begin
                w.data_byte        = sample_q[k];
                w.last_byte        = (k == sample_q.size() - 1);
                w.clean_point_hint = (k == hint_at);
                send_word(w, 1'b0, '0);
            end
        end
    endtask

    task automatic build_sample();
        int         kind;
        logic [4:0] nal;
        begin
            sample_q.delete();
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // too short to scan
                repeat ($urandom_range(1, 5)) sample_q.push_back(payload_byte());
            end else if (kind == 1) begin
                repeat ($urandom_range(6, 40)) sample_q.push_back(payload_byte());
            end else begin
                repeat ($urandom_range(0, 2)) sample_q.push_back(payload_byte());
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) == 1)
                        sample_q.push_back(8'h00);
                    sample_q.push_back(8'h00);
                    sample_q.push_back(8'h00);
                    // now and then a broken code
                    if ($urandom_range(0, 7) == 0)
                        sample_q.push_back(8'($urandom_range(0, 255)));
                    else
                        sample_q.push_back(8'h01);
                    case ($urandom_range(0, 5))
                        0:       nal = NAL_TYPE_IDR;
                        1:       nal = NAL_TYPE_AUD;
                        2:       nal = 5'h01;
                        default: nal = 5'($urandom_range(0, 31));
                    endcase
                    sample_q.push_back({3'($urandom_range(0, 7)), nal});
                    repeat ($urandom_range(0, 14)) sample_q.push_back(payload_byte());
                end
            end
        end
    endtask

    // stimulus
    initial begin
        int start_sent;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].res);

        rand_phase = 1'b1;
        start_sent = n_sent;
        while (n_sent - start_sent < RANDOM_WORDS) begin
            build_sample();
            if ($urandom_range(0, 3) == 0)
                send_sample($urandom_range(0, sample_q.size() - 1));
            else
                send_sample(-1);
        end
        i_in_valid <= 1'b0;

        while (pending_frags.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (n_bad == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // long receiver hold-off while words keep coming
    initial begin
        while (!rand_phase)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold <= 1'b0;
    end

    // result side: check taken words, then pick the next ready
    always @(posedge i_clk) begin : rx_side
        t_out_word want;
        int        r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_frags.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("tb_top: unexpected result %s", fmt_word(o_out_word));
            end else begin
                want = pending_frags.pop_front();
                if (o_out_word.fragment_valid  !== want.fragment_valid  ||
                    o_out_word.fragment_offset !== want.fragment_offset ||
                    o_out_word.fragment_length !== want.fragment_length ||
                    o_out_word.fragment_index  !== want.fragment_index  ||
                    o_out_word.frame_end       !== want.frame_end       ||
                    o_out_word.key_frame       !== want.key_frame       ||
                    o_out_word.fragment_count  !== want.fragment_count  ||
                    o_out_word.overflow        !== want.overflow) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("tb_top: mismatch exp %s / got %s",
                                 fmt_word(want), fmt_word(o_out_word));
                end
            end
        end

        if ($urandom_range(0, 127) == 0)
            rx_steady = !rx_steady;
        if (hold) begin
            i_out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            i_out_ready <= 1'b0;
            rx_stall--;
        end else begin
            r = $urandom_range(0, 99);
            if (rx_steady || r < 65) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                rx_stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 24);
            end
        end
    end

endmodule
